### hw/rtl/wwmf_pkg.sv
// Shared types and constants for the winnowing window-minimum fingerprint block.
`default_nettype none

package wwmf_pkg;

    localparam int HASH_W     = 64;
    localparam int WINDOW_DEF = 16;

    typedef logic [HASH_W-1:0] hash_t;

    // Per-item control broadcast from the top level to every cell.
    typedef struct packed {
        logic take;   // an item is accepted in this cycle
        logic shift;  // the front candidate expires, so the row moves one place forward
    } wwmf_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/wwmf_in_if.sv
// Input channel interface carrying one hash item per handshake.
`default_nettype none

interface wwmf_in_if import wwmf_pkg::*; ();

    logic  valid;
    logic  ready;
    hash_t hash_value;
    logic  last_item;

    modport source (output valid, output hash_value, output last_item, input ready);
    modport sink   (input valid, input hash_value, input last_item, output ready);

endinterface

`default_nettype wire

### hw/rtl/wwmf_out_if.sv
// Output channel interface carrying one fingerprint item per handshake.
`default_nettype none

interface wwmf_out_if import wwmf_pkg::*; ();

    logic  valid;
    logic  ready;
    hash_t fingerprint;

    modport source (output valid, output fingerprint, input ready);
    modport sink   (input valid, input fingerprint, output ready);

endinterface

`default_nettype wire

### hw/rtl/wwmf_cell.sv
// One deque cell: holds a candidate hash and its age, and compares it with the new hash.
`default_nettype none

module wwmf_cell import wwmf_pkg::*; #(
    parameter int AGE_W = 5
) (
    input  wire logic             clk,
    input  wire wwmf_ctrl_t       ctrl,
    input  wire hash_t            hash_value,
    input  wire logic             own_valid,
    input  wire logic             next_valid,
    input  wire hash_t            next_value,
    input  wire logic [AGE_W-1:0] next_age,
    input  wire logic             prev_keep,
    output hash_t                 value_q,
    output logic [AGE_W-1:0]      age_q,
    output hash_t                 value_s,
    output logic                  keep,
    output logic                  insert
);

    hash_t            value_reg;
    hash_t            value_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             valid_s;
    logic [AGE_W-1:0] age_s;

    // Contents after the optional forward move caused by an expiring front.
    always_comb
    begin
        valid_s = ctrl.shift ? next_valid : own_valid;
        value_s = ctrl.shift ? next_value : value_reg;
        age_s   = ctrl.shift ? next_age   : age_reg;
    end

    // Candidates are strictly increasing towards the back, so kept cells form a prefix.
    assign keep   = valid_s && (value_s < hash_value);
    assign insert = !keep && prev_keep;

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.take)
        begin
            if (insert)
            begin
                value_next = hash_value;
                age_next   = AGE_W'(1);
            end
            else if (keep)
            begin
                value_next = value_s;
                age_next   = age_s + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign value_q = value_reg;
    assign age_q   = age_reg;

endmodule

`default_nettype wire

### hw/rtl/winnowing_window_min_fingerprint_top.sv
// Top level of the winnowing fingerprint block: a row of deque cells plus result logic.
// Latency: a result item is presented in the cycle after the input item that causes it.
// Throughput: one input item per cycle while no result waits on a stalled sink; every cell
// tests the new hash at once, so the deque update (expire, pop, append) is combinational.
// Reset: rst_n clears the candidate count, position, last minimum and filled flag at once;
// candidate contents need no clearing because only entries below the count are ever used.
`default_nettype none

module winnowing_window_min_fingerprint_top import wwmf_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wwmf_in_if.sink     in_ch,
    wwmf_out_if.source  out_ch
);

    // The count and the ages both range over 0..WINDOW.
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int AGE_W = CNT_W;
    // The item position only matters until the first window is complete.
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    wwmf_ctrl_t       ctrl;
    logic             take;
    logic             expire;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    hash_t            prev_min_reg;
    hash_t            prev_min_next;
    logic             filled_reg;
    logic             filled_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    hash_t            fingerprint_reg;
    hash_t            fingerprint_next;

    logic [WINDOW-1:0] valid_vec;
    logic [WINDOW-1:0] keep_vec;
    logic [WINDOW-1:0] insert_vec;
    hash_t             value_q [WINDOW];
    logic [AGE_W-1:0]  age_q   [WINDOW];
    hash_t             front_s;
    hash_t             front;
    logic              emit;

    // The block takes a new item whenever the output register is empty or being drained,
    // so a result holds back the next item only while the sink is not ready to take it.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;

    // Only the front candidate can be a full window old: positions in the deque strictly
    // increase and the front is checked on every item.
    assign expire     = (count_reg != '0) && (age_q[0] >= AGE_W'(WINDOW));
    assign ctrl.take  = take;
    assign ctrl.shift = expire;

    // The count register is the deque's fill level; each cell below it holds a candidate.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            valid_vec[i] = CNT_W'(i) < count_reg;
        end
    end

    // The row of cells. Each cell looks at its back neighbour for the forward move and at
    // its front neighbour's keep flag to know whether the new hash lands in it.
    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        logic             nb_valid;
        hash_t            nb_value;
        logic [AGE_W-1:0] nb_age;
        logic             pk;

        if (g == WINDOW - 1)
        begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_value = '0;
            assign nb_age   = '0;
        end
        else
        begin : g_mid
            assign nb_valid = valid_vec[g+1];
            assign nb_value = value_q[g+1];
            assign nb_age   = age_q[g+1];
        end

        if (g == 0)
        begin : g_head
            assign pk = 1'b1;
            wwmf_cell #(
                .AGE_W (AGE_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .hash_value (in_ch.hash_value),
                .own_valid  (valid_vec[g]),
                .next_valid (nb_valid),
                .next_value (nb_value),
                .next_age   (nb_age),
                .prev_keep  (pk),
                .value_q    (value_q[g]),
                .age_q      (age_q[g]),
                .value_s    (front_s),
                .keep       (keep_vec[g]),
                .insert     (insert_vec[g])
            );
        end
        else
        begin : g_body
            assign pk = keep_vec[g-1];
            wwmf_cell #(
                .AGE_W (AGE_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .hash_value (in_ch.hash_value),
                .own_valid  (valid_vec[g]),
                .next_valid (nb_valid),
                .next_value (nb_value),
                .next_age   (nb_age),
                .prev_keep  (pk),
                .value_q    (value_q[g]),
                .age_q      (age_q[g]),
                .value_s    (),
                .keep       (keep_vec[g]),
                .insert     (insert_vec[g])
            );
        end
    end

    // The window minimum after this item: the surviving front, or the new hash itself.
    assign front = keep_vec[0] ? front_s : in_ch.hash_value;

    // New fill level: one past the cell that receives the new hash.
    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            count_next = count_next | (insert_vec[i] ? CNT_W'(i + 1) : '0);
        end
    end

    always_comb
    begin
        emit          = 1'b0;
        prev_min_next = prev_min_reg;
        filled_next   = filled_reg;
        pos_next      = pos_reg;
        if (!filled_reg)
        begin
            if (pos_reg == POS_W'(WINDOW - 1))
            begin
                // First full window: report its minimum even on a last item.
                filled_next   = 1'b1;
                prev_min_next = front;
                emit          = 1'b1;
            end
            else
            begin
                // A short sequence reports the minimum of what it has seen.
                emit     = in_ch.last_item;
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (front != prev_min_reg)
        begin
            prev_min_next = front;
            emit          = 1'b1;
        end
    end

    // Output register: loaded by a reporting item, emptied when the sink takes it.
    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ch.ready;
        fingerprint_next = fingerprint_reg;
        if (take && emit)
        begin
            out_valid_next   = 1'b1;
            fingerprint_next = front;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            prev_min_reg  <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (in_ch.last_item)
                begin
                    // The end of a sequence returns the deque to its starting state.
                    count_reg    <= '0;
                    pos_reg      <= '0;
                    prev_min_reg <= '0;
                    filled_reg   <= 1'b0;
                end
                else
                begin
                    count_reg    <= count_next;
                    pos_reg      <= pos_next;
                    prev_min_reg <= prev_min_next;
                    filled_reg   <= filled_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fingerprint_reg <= fingerprint_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.fingerprint = fingerprint_reg;

    // Exactly one cell takes the new hash on every accepted item.
    a_one_insert : assert property (@(posedge clk) disable iff (!rst_n)
        take |-> $onehot(insert_vec))
        else $error("new hash not placed in exactly one cell");

    // The deque never holds more candidates than the window is long.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("candidate count beyond window");

    // A last item leaves the block empty for the next sequence.
    a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_ch.last_item) |=> (count_reg == '0) && !filled_reg && (pos_reg == '0))
        else $error("state not cleared after last item");

    // A result is never overwritten before the sink has taken it.
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg && $stable(fingerprint_reg))
        else $error("pending result lost");

endmodule

`default_nettype wire
